[rtl/b2b_pkg.sv]
// ----------------------------------------------------------------------------
// b2b_pkg
// Shared types, constants and schedule tables for the BLAKE2b hash core.
// ----------------------------------------------------------------------------
package b2b_pkg;

    typedef logic [63:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_MIX,
        ST_FOLD,
        ST_EMIT
    } state_t;

    localparam logic [2:0] REG_DIGEST  = 3'd0;
    localparam logic [2:0] REG_KEY     = 3'd1;
    localparam logic [2:0] REG_SALT_LO = 3'd2;
    localparam logic [2:0] REG_SALT_HI = 3'd3;
    localparam logic [2:0] REG_PERS_LO = 3'd4;
    localparam logic [2:0] REG_PERS_HI = 3'd5;

    localparam int ROUNDS = 12;

    // one G operand set: v indexes and message selects
    typedef struct packed {
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] c;
        logic [3:0] d;
        logic [3:0] mx;
        logic [3:0] my;
    } gsel_t;

    function automatic word_t iv(input logic [2:0] k);
        word_t r;
        case (k)
            3'd0: r = 64'h6a09e667f3bcc908;
            3'd1: r = 64'hbb67ae8584caa73b;
            3'd2: r = 64'h3c6ef372fe94f82b;
            3'd3: r = 64'ha54ff53a5f1d36f1;
            3'd4: r = 64'h510e527fade682d1;
            3'd5: r = 64'h9b05688c2b3e6c1f;
            3'd6: r = 64'h1f83d9abfb41bd6b;
            default: r = 64'h5be0cd19137e2179;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] sigma_row(input logic [3:0] r);
        logic [63:0] s;
        case (r)
            4'd0, 4'd10: s = 64'hfedcba9876543210;
            4'd1, 4'd11: s = 64'h357b20c16df984ae;
            4'd2:  s = 64'h491763eadf250c8b;
            4'd3:  s = 64'h8f04a562ebcd1397;
            4'd4:  s = 64'hd386cb1efa427509;
            4'd5:  s = 64'h91ef57d438b0a6c2;
            4'd6:  s = 64'hb8293670a4def15c;
            4'd7:  s = 64'ha2684f05931ce7bd;
            4'd8:  s = 64'h5a417d2c803b9ef6;
            default: s = 64'h0dc3e9bf5167482a;
        endcase
        return s;
    endfunction

    function automatic gsel_t gsel(input logic [3:0] r, input logic [2:0] g);
        gsel_t q;
        logic [63:0] s;
        s = sigma_row(r);
        q.mx = s[{g, 1'b0, 2'b00} +: 4];
        q.my = s[{g, 1'b1, 2'b00} +: 4];
        case (g)
            3'd0: {q.a, q.b, q.c, q.d} = {4'd0, 4'd4, 4'd8, 4'd12};
            3'd1: {q.a, q.b, q.c, q.d} = {4'd1, 4'd5, 4'd9, 4'd13};
            3'd2: {q.a, q.b, q.c, q.d} = {4'd2, 4'd6, 4'd10, 4'd14};
            3'd3: {q.a, q.b, q.c, q.d} = {4'd3, 4'd7, 4'd11, 4'd15};
            3'd4: {q.a, q.b, q.c, q.d} = {4'd0, 4'd5, 4'd10, 4'd15};
            3'd5: {q.a, q.b, q.c, q.d} = {4'd1, 4'd6, 4'd11, 4'd12};
            3'd6: {q.a, q.b, q.c, q.d} = {4'd2, 4'd7, 4'd8, 4'd13};
            default: {q.a, q.b, q.c, q.d} = {4'd3, 4'd4, 4'd9, 4'd14};
        endcase
        return q;
    endfunction

endpackage

[rtl/b2b_half_g.sv]
// ----------------------------------------------------------------------------
// b2b_half_g
// Half of a G mix: one add pair and two xor-rotates, shared by all mixes.
// ----------------------------------------------------------------------------
module b2b_half_g (
    input  b2b_pkg::word_t a,
    input  b2b_pkg::word_t b,
    input  b2b_pkg::word_t c,
    input  b2b_pkg::word_t d,
    input  b2b_pkg::word_t m,
    input  logic           second,
    output b2b_pkg::word_t a_o,
    output b2b_pkg::word_t b_o,
    output b2b_pkg::word_t c_o,
    output b2b_pkg::word_t d_o
);
    b2b_pkg::word_t dx;
    b2b_pkg::word_t bx;

    assign a_o = a + b + m;
    assign dx  = d ^ a_o;
    // rotate by 32 then 16 on the second half
    assign d_o = second ? {dx[15:0], dx[63:16]} : {dx[31:0], dx[63:32]};
    assign c_o = c + d_o;
    assign bx  = b ^ c_o;
    assign b_o = second ? {bx[62:0], bx[63]} : {bx[23:0], bx[63:24]};
endmodule

[rtl/blake2b_hash_core.sv]
// ----------------------------------------------------------------------------
// blake2b_hash_core
// Unkeyed BLAKE2b: gathers 16 words, compresses on one shared half-G unit.
// ----------------------------------------------------------------------------
// A word that does not end a block is taken in any cycle with start high and busy low.
// A block end keeps the core busy through init, twelve rounds of half-G steps and a fold;
// no word is taken meanwhile, as the single half-G datapath does all the mixing.
// After the last block eight hash words strobe out on consecutive cycles.
// The receiver cannot stall. Reset (rst_n low, async) restores defaults.
module blake2b_hash_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] msg_word,
    input  logic        final_block,
    input  logic [63:0] total_length,
    output logic        done,
    output logic [63:0] hash_word,
    output logic        last_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    b2b_pkg::state_t state_reg, state_next;
    b2b_pkg::word_t  m_reg [16];
    b2b_pkg::word_t  v_reg [16];
    b2b_pkg::word_t  h_reg [8];
    b2b_pkg::word_t  cnt_reg, ctr_reg;
    logic            last_reg;
    logic [3:0]      widx_reg;
    logic [3:0]      rnd_reg;
    logic [2:0]      g_reg;
    logic            half_reg;
    logic [2:0]      k_reg;
    logic [6:0]      dig_reg, key_reg;
    b2b_pkg::word_t  slo_reg, shi_reg, plo_reg, phi_reg;
    logic            reload;

    b2b_pkg::gsel_t  sel;
    b2b_pkg::word_t  ga, gb, gc, gd;
    logic            accept, cfg_hit;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index <= b2b_pkg::REG_PERS_HI);
    assign busy      = state_reg != b2b_pkg::ST_IDLE;

    assign sel = b2b_pkg::gsel(rnd_reg, g_reg);

    b2b_half_g u_g (
        .a(v_reg[sel.a]), .b(v_reg[sel.b]), .c(v_reg[sel.c]), .d(v_reg[sel.d]),
        .m(half_reg ? m_reg[sel.my] : m_reg[sel.mx]), .second(half_reg),
        .a_o(ga), .b_o(gb), .c_o(gc), .d_o(gd)
    );

    function automatic b2b_pkg::word_t pword(input logic [2:0] k, input logic [6:0] dg,
        input logic [6:0] ky, input b2b_pkg::word_t s0, input b2b_pkg::word_t s1,
        input b2b_pkg::word_t p0, input b2b_pkg::word_t p1);
        b2b_pkg::word_t w;
        case (k)
            3'd0: w = {32'd0, 8'd1, 8'd1, 1'b0, ky, 1'b0, dg};
            3'd4: w = s0;
            3'd5: w = s1;
            3'd6: w = p0;
            3'd7: w = p1;
            default: w = '0;
        endcase
        return b2b_pkg::iv(k) ^ w;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            b2b_pkg::ST_IDLE: if (accept && widx_reg == 4'd15) state_next = b2b_pkg::ST_INIT;
            b2b_pkg::ST_INIT: state_next = b2b_pkg::ST_MIX;
            b2b_pkg::ST_MIX:
                if (half_reg && g_reg == 3'd7 && rnd_reg == 4'(b2b_pkg::ROUNDS - 1))
                    state_next = b2b_pkg::ST_FOLD;
            b2b_pkg::ST_FOLD: state_next = last_reg ? b2b_pkg::ST_EMIT : b2b_pkg::ST_IDLE;
            b2b_pkg::ST_EMIT: if (k_reg == 3'd7) state_next = b2b_pkg::ST_IDLE;
            default: state_next = b2b_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= b2b_pkg::ST_IDLE;
            widx_reg  <= '0;
            cnt_reg   <= '0;
            rnd_reg   <= '0;
            g_reg     <= '0;
            half_reg  <= 1'b0;
            k_reg     <= '0;
            last_reg  <= 1'b0;
            reload    <= 1'b1;
            dig_reg   <= 7'd64;
            key_reg   <= '0;
            slo_reg   <= '0;
            shi_reg   <= '0;
            plo_reg   <= '0;
            phi_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            reload    <= 1'b0;
            if (cfg_hit)
            begin
                case (cfg_index)
                    b2b_pkg::REG_DIGEST:  dig_reg <= cfg_data[6:0];
                    b2b_pkg::REG_KEY:     key_reg <= cfg_data[6:0];
                    b2b_pkg::REG_SALT_LO: slo_reg <= cfg_data;
                    b2b_pkg::REG_SALT_HI: shi_reg <= cfg_data;
                    b2b_pkg::REG_PERS_LO: plo_reg <= cfg_data;
                    default:              phi_reg <= cfg_data;
                endcase
                if (widx_reg == 4'd0 && cnt_reg == '0)
                    reload <= 1'b1;
            end
            if (accept)
            begin
                widx_reg <= widx_reg + 4'd1;
                if (widx_reg == 4'd15)
                begin
                    last_reg <= final_block;
                    if (!final_block)
                        cnt_reg <= cnt_reg + 64'd128;
                end
            end
            if (state_reg == b2b_pkg::ST_MIX)
            begin
                half_reg <= !half_reg;
                if (half_reg)
                begin
                    g_reg <= g_reg + 3'd1;
                    if (g_reg == 3'd7)
                        rnd_reg <= (rnd_reg == 4'(b2b_pkg::ROUNDS - 1)) ? 4'd0
                                                                        : rnd_reg + 4'd1;
                end
            end
            if (state_reg == b2b_pkg::ST_EMIT)
            begin
                k_reg <= k_reg + 3'd1;
                if (k_reg == 3'd7)
                begin
                    cnt_reg <= '0;
                    reload  <= 1'b1;
                end
            end
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_reg[widx_reg] <= msg_word;
            if (widx_reg == 4'd15)
                ctr_reg <= final_block ? total_length : cnt_reg + 64'd128;
        end
        if (reload)
            for (int k = 0; k < 8; k++)
                h_reg[k] <= pword(3'(k), dig_reg, key_reg, slo_reg, shi_reg,
                                  plo_reg, phi_reg);
        if (state_reg == b2b_pkg::ST_INIT)
            for (int k = 0; k < 8; k++)
            begin
                v_reg[k] <= h_reg[k];
                if (k == 4)
                    v_reg[12] <= b2b_pkg::iv(3'd4) ^ ctr_reg;
                else if (k == 6)
                    v_reg[14] <= b2b_pkg::iv(3'd6) ^ {64{last_reg}};
                else
                    v_reg[k+8] <= b2b_pkg::iv(3'(k));
            end
        if (state_reg == b2b_pkg::ST_MIX)
        begin
            v_reg[sel.a] <= ga;
            v_reg[sel.b] <= gb;
            v_reg[sel.c] <= gc;
            v_reg[sel.d] <= gd;
        end
        if (state_reg == b2b_pkg::ST_FOLD)
            for (int k = 0; k < 8; k++)
                h_reg[k] <= h_reg[k] ^ v_reg[k] ^ v_reg[k+8];
    end

    assign done      = state_reg == b2b_pkg::ST_EMIT;
    assign hash_word = h_reg[k_reg];
    assign last_word = done && k_reg == 3'd7;
endmodule

[rtl/b2b_checker.sv]
// ----------------------------------------------------------------------------
// b2b_checker
// Port-level checks for the BLAKE2b hash core.
// ----------------------------------------------------------------------------
module b2b_checker (
    input logic clk,
    input logic rst_n,
    input logic busy,
    input logic done,
    input logic last_word
);
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        last_word |-> done) else $error("last_word without done");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done while idle");
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        last_word |=> !done) else $error("extra beat after last word");
    a_done_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> ##7 last_word) else $error("burst not eight beats");
endmodule

bind blake2b_hash_core b2b_checker u_chk (
    .clk(clk), .rst_n(rst_n), .busy(busy),
    .done(done), .last_word(last_word)
);
